>>> sv/start_byte_length_field_deframer_defines.svh
// assertion macros for the start byte length field deframer
`ifndef START_BYTE_LENGTH_FIELD_DEFRAMER_DEFINES_SVH
`define START_BYTE_LENGTH_FIELD_DEFRAMER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SBLDF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define SBLDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/sbldf_pkg.sv
// types, codes and frame constants shared by the deframer modules
package sbldf_pkg;

   // frame geometry
   localparam int unsigned HEADER_BYTES = 8;
   localparam int unsigned MAX_PAYLOAD  = 32;
   localparam int unsigned CRC_BYTES    = 2;

   // field widths
   localparam int unsigned POS_W  = 6;
   localparam int unsigned SUM_W  = 10;
   localparam int unsigned TIME_W = 16;

   // header byte that carries the payload length
   localparam logic [POS_W-1:0] LEN_POS = POS_W'(6);

   // start marker after reset
   localparam logic [7:0] START_MARKER_RESET = 8'd170;

   // request action codes
   localparam logic [1:0] ACT_ARM  = 2'd0;
   localparam logic [1:0] ACT_BYTE = 2'd1;
   localparam logic [1:0] ACT_TICK = 2'd2;

   // response status codes
   localparam logic [1:0] ST_STORED   = 2'd0;
   localparam logic [1:0] ST_COMPLETE = 2'd1;
   localparam logic [1:0] ST_TIMEOUT  = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_HUNT   = 2'd1,
      PH_HEADER = 2'd2,
      PH_BODY   = 2'd3
   } phase_type;

   typedef struct packed {
      logic [1:0]        action;
      logic [7:0]        byte_value;
      logic [TIME_W-1:0] timeout_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [7:0]       data_byte;
      logic [POS_W-1:0] byte_index;
      logic [POS_W-1:0] frame_size;
      logic             last;
   } rsp_type;

   // result of one word from the core
   typedef struct packed {
      logic    valid;
      rsp_type item;
   } core_out_type;

endpackage

>>> sv/sbldf_core.sv
// frame read state machine: hunt, header, body and millisecond timeout
`include "start_byte_length_field_deframer_defines.svh"

module sbldf_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_accept,
   input  sbldf_pkg::req_type     item,
   input  logic [7:0]             start_marker,
   output sbldf_pkg::core_out_type result
);

   sbldf_pkg::phase_type                 phase_ff, phase_in;
   logic [sbldf_pkg::POS_W-1:0]          position_ff, position_in;
   logic [sbldf_pkg::POS_W-1:0]          expected_ff, expected_in;
   logic [sbldf_pkg::TIME_W-1:0]         elapsed_ff, elapsed_in;
   logic [sbldf_pkg::TIME_W-1:0]         deadline_ff, deadline_in;
   logic [7:0]                           length_ff, length_in;

   logic [sbldf_pkg::POS_W-1:0]          pos_inc;
   logic [sbldf_pkg::TIME_W-1:0]         elapsed_inc;
   logic [7:0]                           len_cur;
   logic [sbldf_pkg::SUM_W-1:0]          size_sum;
   logic [sbldf_pkg::POS_W-1:0]          size_cur;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= sbldf_pkg::PH_IDLE;
         position_ff <= '0;
         expected_ff <= '0;
         elapsed_ff  <= '0;
         deadline_ff <= '0;
         length_ff   <= '0;
      end else if (item_accept) begin
         phase_ff    <= phase_in;
         position_ff <= position_in;
         expected_ff <= expected_in;
         elapsed_ff  <= elapsed_in;
         deadline_ff <= deadline_in;
         length_ff   <= length_in;
      end
   end

   // shared arithmetic
   assign pos_inc     = position_ff + sbldf_pkg::POS_W'(1);
   assign elapsed_inc = (elapsed_ff != {sbldf_pkg::TIME_W{1'b1}}) ?
                        elapsed_ff + sbldf_pkg::TIME_W'(1) : elapsed_ff;
   assign len_cur     = (position_ff == sbldf_pkg::LEN_POS) ? item.byte_value : length_ff;
   assign size_sum    = sbldf_pkg::SUM_W'(sbldf_pkg::HEADER_BYTES)
                      + sbldf_pkg::SUM_W'(len_cur)
                      + sbldf_pkg::SUM_W'(sbldf_pkg::CRC_BYTES);
   assign size_cur    = size_sum[sbldf_pkg::POS_W-1:0];

   // next state and result for the current word
   always_comb begin
      phase_in     = phase_ff;
      position_in  = position_ff;
      expected_in  = expected_ff;
      elapsed_in   = elapsed_ff;
      deadline_in  = deadline_ff;
      length_in    = length_ff;
      result       = '0;

      if (item.action == sbldf_pkg::ACT_ARM) begin
         // restart the read
         phase_in    = sbldf_pkg::PH_HUNT;
         position_in = '0;
         expected_in = '0;
         elapsed_in  = '0;
         deadline_in = item.timeout_ms;
         length_in   = '0;
      end else if (phase_ff != sbldf_pkg::PH_IDLE) begin
         case (item.action)
            sbldf_pkg::ACT_TICK: begin
               elapsed_in = elapsed_inc;
               if (elapsed_inc >= deadline_ff) begin
                  phase_in         = sbldf_pkg::PH_IDLE;
                  result.valid     = 1'b1;
                  result.item.status = sbldf_pkg::ST_TIMEOUT;
                  result.item.last = 1'b1;
               end
            end
            sbldf_pkg::ACT_BYTE: begin
               case (phase_ff)
                  sbldf_pkg::PH_HUNT: begin
                     // wait for the start marker
                     if (item.byte_value == start_marker) begin
                        phase_in              = sbldf_pkg::PH_HEADER;
                        position_in           = sbldf_pkg::POS_W'(1);
                        result.valid          = 1'b1;
                        result.item.status    = sbldf_pkg::ST_STORED;
                        result.item.data_byte = item.byte_value;
                     end
                  end
                  sbldf_pkg::PH_HEADER: begin
                     position_in            = pos_inc;
                     length_in              = len_cur;
                     result.valid           = 1'b1;
                     result.item.status     = sbldf_pkg::ST_STORED;
                     result.item.data_byte  = item.byte_value;
                     result.item.byte_index = position_ff;
                     if (pos_inc >= sbldf_pkg::POS_W'(sbldf_pkg::HEADER_BYTES)) begin
                        // header done: check the length field
                        if (len_cur > 8'(sbldf_pkg::MAX_PAYLOAD)) begin
                           phase_in               = sbldf_pkg::PH_IDLE;
                           result.item.status     = sbldf_pkg::ST_OVERFLOW;
                           result.item.data_byte  = len_cur;
                           result.item.byte_index = sbldf_pkg::LEN_POS;
                           result.item.last       = 1'b1;
                        end else begin
                           expected_in = size_cur;
                           phase_in    = sbldf_pkg::PH_BODY;
                           if (pos_inc >= size_cur) begin
                              phase_in               = sbldf_pkg::PH_IDLE;
                              result.item.status     = sbldf_pkg::ST_COMPLETE;
                              result.item.frame_size = size_cur;
                              result.item.last       = 1'b1;
                           end
                        end
                     end
                  end
                  sbldf_pkg::PH_BODY: begin
                     position_in            = pos_inc;
                     result.valid           = 1'b1;
                     result.item.status     = sbldf_pkg::ST_STORED;
                     result.item.data_byte  = item.byte_value;
                     result.item.byte_index = position_ff;
                     if (pos_inc >= expected_ff) begin
                        phase_in               = sbldf_pkg::PH_IDLE;
                        result.item.status     = sbldf_pkg::ST_COMPLETE;
                        result.item.frame_size = expected_ff;
                        result.item.last       = 1'b1;
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // checks on the read sequencing
   `SBLDF_ASSERT_NEXT(a_last_ends_read, clock, reset,
      item_accept && result.valid && result.item.last,
      phase_ff == sbldf_pkg::PH_IDLE, "read still active after a last word")
   `SBLDF_ASSERT_NEXT(a_arm_restarts, clock, reset,
      item_accept && item.action == sbldf_pkg::ACT_ARM,
      phase_ff == sbldf_pkg::PH_HUNT && position_ff == '0, "arm did not restart the read")
   `SBLDF_ASSERT_NOW(a_body_bounds, clock, reset,
      phase_ff == sbldf_pkg::PH_BODY,
      position_ff < expected_ff, "body position beyond frame size")
   `SBLDF_ASSERT_NOW(a_header_bounds, clock, reset,
      phase_ff == sbldf_pkg::PH_HEADER,
      position_ff != '0 && position_ff < sbldf_pkg::POS_W'(sbldf_pkg::HEADER_BYTES),
      "header position out of range")
   `SBLDF_ASSERT_NOW(a_complete_size, clock, reset,
      result.valid && result.item.status == sbldf_pkg::ST_COMPLETE,
      result.item.frame_size == result.item.byte_index + sbldf_pkg::POS_W'(1),
      "frame size does not follow the final byte index")

endmodule

>>> sv/start_byte_length_field_deframer.sv
// top level of the start byte length field deframer
// Receive deframer for frames opened by a start marker byte and sized by
// header byte 6. Request words (req_valid/req_stall/req_data) carry an arm
// with a timeout in ms, a received byte, or a one millisecond tick. Response
// words (rsp_valid/rsp_stall/rsp_data) report each kept byte with its index,
// frame completion with the frame size, a timeout or a length overflow; the
// word that ends a read has last set. Arms and dropped bytes or ticks give no
// response word. The start marker is written through csr_valid/csr_ready/
// csr_data, always ready; the user must write it only while no read is in
// progress, unenforced by the block. Throughput is one request word per cycle
// unless stalled; the response is computed with the state update and
// registered, so it appears in the cycle after its request is taken. req_stall
// rises only while the response register holds a word the receiver is
// stalling; a stalled word holds steady. Synchronous reset returns the block
// to idle, clears the response register and sets the start marker back to 170.
module start_byte_length_field_deframer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sbldf_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sbldf_pkg::rsp_type  rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [7:0]          csr_data
);

   logic                    req_accept;
   logic [7:0]              marker_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   sbldf_pkg::rsp_type      rsp_ff, rsp_in;
   sbldf_pkg::core_out_type core_out;

   // handshake
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // start marker register
   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= sbldf_pkg::START_MARKER_RESET;
      end else if (csr_valid && csr_ready) begin
         marker_ff <= csr_data;
      end
   end

   sbldf_core u_core (
      .clock        (clock),
      .reset        (reset),
      .item_accept  (req_accept),
      .item         (req_data),
      .start_marker (marker_ff),
      .result       (core_out)
   );

   // response register next value
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (req_accept && core_out.valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = core_out.item;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the start byte length field deframer
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT       = 1_000_000;
   localparam int unsigned HOLD_CYCLES       = 300;
   localparam int unsigned WORDS_PER_SETTING = 200;
   localparam int unsigned MAX_REPORTS       = 10;
   localparam int unsigned MS_CEILING        = (1 << sbldf_pkg::TIME_W) - 1;
   localparam int unsigned REQ_W             = $bits(sbldf_pkg::req_type);

   // the one action code that the package leaves unnamed
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // frame predictor and the replies it still waits for
   class deframe_scoreboard;
      logic [7:0]           marker;
      sbldf_pkg::phase_type phase;
      int unsigned          next_pos;
      int unsigned          frame_bytes;
      int unsigned          elapsed_ms;
      int unsigned          deadline_ms;
      logic [7:0]           length_field;
      sbldf_pkg::rsp_type   awaited_replies[$];
      int unsigned          failures;
      int unsigned          reports;
      int unsigned          live_words;

      function new();
         marker       = sbldf_pkg::START_MARKER_RESET;
         phase        = sbldf_pkg::PH_IDLE;
         next_pos     = 0;
         frame_bytes  = 0;
         elapsed_ms   = 0;
         deadline_ms  = 0;
         length_field = '0;
         failures     = 0;
         reports      = 0;
         live_words   = 0;
      endfunction

      function void write_marker(logic [7:0] value);
         marker = value;
      endfunction

      function int unsigned pending();
         return awaited_replies.size();
      endfunction

      function void await_reply(logic [1:0] status, logic [7:0] data, int unsigned index,
                                int unsigned size, logic last);
         sbldf_pkg::rsp_type r;
         r.status     = status;
         r.data_byte  = data;
         r.byte_index = sbldf_pkg::POS_W'(index);
         r.frame_size = sbldf_pkg::POS_W'(size);
         r.last       = last;
         awaited_replies.push_back(r);
      endfunction

      // advance the read state by one accepted word
      function void take_request(sbldf_pkg::req_type w);
         int unsigned index;
         // arm restarts the read whatever the phase
         if (w.action == sbldf_pkg::ACT_ARM) begin
            phase        = sbldf_pkg::PH_HUNT;
            next_pos     = 0;
            frame_bytes  = 0;
            elapsed_ms   = 0;
            deadline_ms  = 32'(w.timeout_ms);
            length_field = '0;
            live_words++;
            return;
         end
         if (phase == sbldf_pkg::PH_IDLE ||
             !(w.action inside {sbldf_pkg::ACT_BYTE, sbldf_pkg::ACT_TICK}))
            return;
         // millisecond tick, saturating count
         if (w.action == sbldf_pkg::ACT_TICK) begin
            live_words++;
            if (elapsed_ms < MS_CEILING)
               elapsed_ms++;
            if (elapsed_ms >= deadline_ms) begin
               phase = sbldf_pkg::PH_IDLE;
               await_reply(sbldf_pkg::ST_TIMEOUT, 8'h00, 0, 0, 1'b1);
            end
            return;
         end
         // hunting for the start marker
         if (phase == sbldf_pkg::PH_HUNT) begin
            if (w.byte_value != marker)
               return;
            live_words++;
            next_pos = 1;
            phase    = sbldf_pkg::PH_HEADER;
            await_reply(sbldf_pkg::ST_STORED, w.byte_value, 0, 0, 1'b0);
            return;
         end
         live_words++;
         index = next_pos;
         next_pos++;
         // header bytes, length check on the final one
         if (phase == sbldf_pkg::PH_HEADER) begin
            if (index == 32'(sbldf_pkg::LEN_POS))
               length_field = w.byte_value;
            if (next_pos < sbldf_pkg::HEADER_BYTES) begin
               await_reply(sbldf_pkg::ST_STORED, w.byte_value, index, 0, 1'b0);
               return;
            end
            if (32'(length_field) > sbldf_pkg::MAX_PAYLOAD) begin
               phase = sbldf_pkg::PH_IDLE;
               await_reply(sbldf_pkg::ST_OVERFLOW, length_field,
                           32'(sbldf_pkg::LEN_POS), 0, 1'b1);
               return;
            end
            frame_bytes = sbldf_pkg::HEADER_BYTES + 32'(length_field) + sbldf_pkg::CRC_BYTES;
            phase       = sbldf_pkg::PH_BODY;
         end
         // payload and crc
         if (next_pos >= frame_bytes) begin
            phase = sbldf_pkg::PH_IDLE;
            await_reply(sbldf_pkg::ST_COMPLETE, w.byte_value, index, frame_bytes, 1'b1);
         end else begin
            await_reply(sbldf_pkg::ST_STORED, w.byte_value, index, 0, 1'b0);
         end
      endfunction

      // compare one accepted reply with the oldest one awaited
      function void check_reply(sbldf_pkg::rsp_type got);
         sbldf_pkg::rsp_type want;
         if (awaited_replies.size() == 0) begin
            failures++;
            if (reports < MAX_REPORTS) begin
               reports++;
               $display("unexpected reply: status %0d data %02h index %0d size %0d last %0b",
                        got.status, got.data_byte, got.byte_index, got.frame_size, got.last);
            end
            return;
         end
         want = awaited_replies.pop_front();
         if (got.status !== want.status || got.data_byte !== want.data_byte ||
             got.byte_index !== want.byte_index || got.frame_size !== want.frame_size ||
             got.last !== want.last) begin
            failures++;
            if (reports < MAX_REPORTS) begin
               reports++;
               $display("reply mismatch: expected status %0d data %02h index %0d %s",
                        want.status, want.data_byte, want.byte_index,
                        $sformatf("size %0d last %0b", want.frame_size, want.last));
               $display("                got      status %0d data %02h index %0d %s",
                        got.status, got.data_byte, got.byte_index,
                        $sformatf("size %0d last %0b", got.frame_size, got.last));
            end
         end
      endfunction
   endclass

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   sbldf_pkg::req_type  req_data  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   sbldf_pkg::rsp_type  rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [7:0]          csr_data  = '0;

   deframe_scoreboard sb;
   logic [7:0]  cur_marker  = sbldf_pkg::START_MARKER_RESET;
   int unsigned gap_pct     = 30;
   bit          hold_wanted = 1'b0;
   bit          holding     = 1'b0;
   int unsigned cycle_count = 0;

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   start_byte_length_field_deframer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // watch every handshake at the clock edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.take_request(req_data);
         if (rsp_valid && !rsp_stall)
            sb.check_reply(rsp_data);
         if (csr_valid && csr_ready)
            sb.write_marker(csr_data);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver: random stalls, one long hold-off on request
   initial begin
      int unsigned n;
      @(posedge clock);
      forever begin
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            holding     = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            holding     = 1'b0;
         end else begin
            case ($urandom_range(0, 9))
               0: begin
                  rsp_stall <= 1'b1;
                  n = $urandom_range(10, 60);
               end
               1, 2, 3: begin
                  rsp_stall <= 1'b1;
                  n = $urandom_range(1, 3);
               end
               default: begin
                  rsp_stall <= 1'b0;
                  n = $urandom_range(1, 30);
               end
            endcase
            repeat (n) @(posedge clock);
         end
      end
   end

   function automatic sbldf_pkg::req_type arm_word(logic [15:0] timeout);
      sbldf_pkg::req_type w;
      w            = sbldf_pkg::req_type'(REQ_W'($urandom));
      w.action     = sbldf_pkg::ACT_ARM;
      w.timeout_ms = timeout;
      return w;
   endfunction

   function automatic sbldf_pkg::req_type byte_word(logic [7:0] value);
      sbldf_pkg::req_type w;
      w            = sbldf_pkg::req_type'(REQ_W'($urandom));
      w.action     = sbldf_pkg::ACT_BYTE;
      w.byte_value = value;
      return w;
   endfunction

   function automatic sbldf_pkg::req_type tick_word();
      sbldf_pkg::req_type w;
      w        = sbldf_pkg::req_type'(REQ_W'($urandom));
      w.action = sbldf_pkg::ACT_TICK;
      return w;
   endfunction

   // offer one word, after an optional gap, and hold it until taken
   task automatic send_word(sbldf_pkg::req_type w);
      int unsigned n;
      if (!holding && $urandom_range(1, 100) <= gap_pct) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
   endtask

   // stop offering and wait for every awaited reply
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // close any open read, then write the start marker
   task automatic change_marker(logic [7:0] value);
      settle();
      if (sb.phase != sbldf_pkg::PH_IDLE) begin
         send_word(arm_word(16'd0));
         send_word(tick_word());
         settle();
      end
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_marker = value;
   endtask

   // idle drops, a full frame, zero timeout, restart and length overflow
   task automatic directed_checks();
      send_word(tick_word());
      send_word(byte_word(sbldf_pkg::START_MARKER_RESET));
      send_word('{action: ACT_UNUSED, byte_value: 8'hFF, timeout_ms: 16'hFFFF});
      send_word(arm_word(16'hFFFF));
      send_word(byte_word(8'h00));
      send_word(byte_word(sbldf_pkg::START_MARKER_RESET));
      send_word(byte_word(8'hFF));
      send_word(byte_word(8'h00));
      send_word('{action: ACT_UNUSED, byte_value: 8'h00, timeout_ms: 16'h0000});
      send_word(byte_word(8'hAA));
      send_word(byte_word(8'h55));
      send_word(byte_word(8'hFF));
      send_word(byte_word(8'h00));
      send_word(byte_word(8'h7F));
      send_word(byte_word(8'h01));
      send_word(byte_word(8'h80));
      // a byte is still taken before the first tick reports the timeout
      send_word(arm_word(16'd0));
      send_word(byte_word(sbldf_pkg::START_MARKER_RESET));
      send_word(tick_word());
      // arm while busy restarts, then the length byte is one too many
      send_word(arm_word(16'd5));
      send_word(byte_word(sbldf_pkg::START_MARKER_RESET));
      send_word(arm_word(16'hFFFF));
      send_word(byte_word(sbldf_pkg::START_MARKER_RESET));
      for (int i = 1; i < sbldf_pkg::HEADER_BYTES; i++)
         send_word(byte_word((i == 32'(sbldf_pkg::LEN_POS)) ?
                             8'(sbldf_pkg::MAX_PAYLOAD + 1) : 8'hFF));
   endtask

   // a frame with random content, sometimes with an oversized length or cut short
   task automatic send_frame();
      int unsigned len;
      int unsigned n;
      int unsigned stop;
      logic [15:0] timeout;
      logic [7:0]  b;
      case ($urandom_range(0, 9))
         0:       timeout = 16'($urandom_range(0, 5));
         1, 2:    timeout = 16'($urandom);
         default: timeout = 16'($urandom_range(1000, 65535));
      endcase
      send_word(arm_word(timeout));
      repeat ($urandom_range(0, 3)) begin
         do b = 8'($urandom); while (b == cur_marker);
         send_word(byte_word(b));
      end
      case ($urandom_range(0, 19))
         0:       len = 0;
         1:       len = sbldf_pkg::MAX_PAYLOAD;
         2:       len = sbldf_pkg::MAX_PAYLOAD + 1;
         3:       len = 255;
         4, 5:    len = $urandom_range(sbldf_pkg::MAX_PAYLOAD + 1, 255);
         default: len = $urandom_range(0, sbldf_pkg::MAX_PAYLOAD);
      endcase
      n    = (len > sbldf_pkg::MAX_PAYLOAD) ? sbldf_pkg::HEADER_BYTES :
             sbldf_pkg::HEADER_BYTES + len + sbldf_pkg::CRC_BYTES;
      stop = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n) : n;
      for (int unsigned i = 0; i < stop; i++) begin
         if ($urandom_range(0, 19) == 0)
            send_word(tick_word());
         if (i == 0)
            b = cur_marker;
         else if (i == 32'(sbldf_pkg::LEN_POS))
            b = len[7:0];
         else
            b = 8'($urandom);
         send_word(byte_word(b));
      end
   endtask

   // short deadline with ticks and bytes mixed
   task automatic send_timeout_run();
      send_word(arm_word(16'($urandom_range(0, 6))));
      repeat ($urandom_range(4, 14)) begin
         case ($urandom_range(0, 2))
            0:       send_word(tick_word());
            1:       send_word(byte_word(cur_marker));
            default: send_word(byte_word(8'($urandom)));
         endcase
      end
   endtask

   // random words of every action, unused code included
   task automatic send_noise();
      sbldf_pkg::req_type w;
      repeat ($urandom_range(3, 12)) begin
         w = sbldf_pkg::req_type'(REQ_W'($urandom));
         if (w.action == sbldf_pkg::ACT_ARM && $urandom_range(0, 1) == 0)
            w.timeout_ms = 16'($urandom_range(0, 4));
         if ($urandom_range(0, 3) == 0)
            w.byte_value = cur_marker;
         send_word(w);
      end
   endtask

   task automatic random_traffic();
      int unsigned start;
      start = sb.live_words;
      while (sb.live_words - start < WORDS_PER_SETTING) begin
         gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 30;
         case ($urandom_range(0, 19))
            0, 1, 2:    send_timeout_run();
            3, 4, 5:    send_noise();
            default:    send_frame();
         endcase
      end
   endtask

   // main sequence
   initial begin
      logic [7:0] m;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_checks();
      for (int k = 0; k < 5; k++) begin
         case (k)
            0:       m = 8'h00;
            1:       m = 8'hFF;
            4:       m = sbldf_pkg::START_MARKER_RESET;
            default: m = 8'($urandom);
         endcase
         change_marker(m);
         // long receiver hold-off while words keep coming
         if (k == 1)
            hold_wanted = 1'b1;
         random_traffic();
      end
      settle();
      if (sb.failures == 0 && sb.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
